[sv/ordered_unique_card_list_assert.svh]
// Assertion macros shared by the card list checker
`ifndef ORDERED_UNIQUE_CARD_LIST_ASSERT_SVH
`define ORDERED_UNIQUE_CARD_LIST_ASSERT_SVH

// Clocked check, masked while reset is held
`define OUC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define OUC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ouc_pkg.sv]
// Shared types, request and status codes for the ordered card list
package ouc_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CARD_W    = 7;
  localparam int CNT_OUT_W = 7;

  // request codes
  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_REM_FIRST = 3'd1;
  localparam logic [2:0] REQ_REM_CARD  = 3'd2;
  localparam logic [2:0] REQ_PEEK      = 3'd3;
  localparam logic [2:0] REQ_COUNT     = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] card_suit;
    logic [3:0] card_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] match_count;
    logic [2:0] head_suit;
    logic [3:0] head_value;
    logic [6:0] occupancy;
  } out_item_t;

endpackage

[sv/ouc_store.sv]
// Card store: one write port, one read port with registered read data
module ouc_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ouc_pkg::CARD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ouc_pkg::CARD_W-1:0] rd_data
);
  import ouc_pkg::*;

  logic [CARD_W-1:0] mem [DEPTH];
  logic [CARD_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/ouc_seq.sv]
// Request sequencer: linear search, gap closing and result assembly
module ouc_seq #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  ouc_pkg::in_item_t          req_data,
  output logic                       idle,
  output logic                       res_valid,
  output ouc_pkg::out_item_t         res_data,
  input  logic                       res_ack,
  output logic                       mem_wr_en,
  output logic [AW-1:0]              mem_wr_addr,
  output logic [ouc_pkg::CARD_W-1:0] mem_wr_data,
  output logic                       mem_rd_en,
  output logic [AW-1:0]              mem_rd_addr,
  input  logic [ouc_pkg::CARD_W-1:0] mem_rd_data
);
  import ouc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH_RD  = 8'b0000_0010,
    S_SRCH_CMP = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_HEAD_WT  = 8'b0001_0000,
    S_SHIFT_RD = 8'b0010_0000,
    S_SHIFT_WR = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t            state_r, state_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [CARD_W-1:0] key_r, key_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              found_r, found_nxt;
  out_item_t         res_r, res_nxt;
  logic [CW-1:0]     idx_inc;

  // shared index incrementer
  assign idx_inc = idx_r + CW'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    res_nxt     = res_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r[AW-1:0];
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt   = req_data.req_type;
          key_nxt   = {req_data.card_suit, req_data.card_value};
          idx_nxt   = '0;
          found_nxt = 1'b0;
          res_nxt   = '0;
          state_nxt = S_SRCH_RD;
        end
      end
      // walk the held entries looking for the key
      S_SRCH_RD: begin
        if (idx_r >= cnt_r) begin
          state_nxt = S_DECIDE;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (mem_rd_data == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH_RD;
        end
      end
      // apply the request now that the search outcome is known
      S_DECIDE: begin
        state_nxt = S_FINISH;
        unique case (req_r)
          REQ_INSERT: begin
            if (found_r) begin
              res_nxt.status      = ST_DUP;
              res_nxt.match_count = 7'd1;
            end else if (cnt_r >= FULL_CNT) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_wr_en           = 1'b1;
              mem_wr_addr         = cnt_r[AW-1:0];
              mem_wr_data         = key_r;
              cnt_nxt             = cnt_r + CW'(1);
              res_nxt.match_count = 7'd1;
            end
          end
          REQ_REM_FIRST: begin
            if (cnt_r == '0) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              // key survives only if it was not the head
              res_nxt.match_count = {6'd0, found_r && (pos_r != '0)};
              idx_nxt             = '0;
              state_nxt           = S_SHIFT_RD;
            end
          end
          REQ_REM_CARD: begin
            if (cnt_r == '0) begin
              res_nxt.status = ST_EMPTY;
            end else if (!found_r) begin
              res_nxt.status = ST_NOTFOUND;
            end else begin
              idx_nxt   = pos_r;
              state_nxt = S_SHIFT_RD;
            end
          end
          REQ_PEEK: begin
            res_nxt.match_count = {6'd0, found_r};
            if (cnt_r == '0) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_nxt   = S_HEAD_WT;
            end
          end
          default: begin
            res_nxt.match_count = {6'd0, found_r};
          end
        endcase
      end
      S_HEAD_WT: begin
        res_nxt.head_suit  = mem_rd_data[6:4];
        res_nxt.head_value = mem_rd_data[3:0];
        state_nxt          = S_FINISH;
      end
      // close the gap one entry at a time
      S_SHIFT_RD: begin
        if (idx_inc < cnt_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_inc[AW-1:0];
          state_nxt   = S_SHIFT_WR;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        mem_wr_en = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result with occupancy taken from the updated count
  always_comb begin
    res_data           = res_r;
    res_data.occupancy = CNT_OUT_W'(cnt_r);
  end

  assign res_valid = (state_r == S_FINISH);
  assign idle      = (state_r == S_IDLE);

endmodule

[sv/ordered_unique_card_list.sv]
// Each request searches the held entries in order; a removal then moves later entries up to
// close the gap. The search and the gap closing share one store read port and one index
// incrementer, so a request is taken only when the sequencer is idle, and a new request is
// not taken before the last one has finished.
// A finished result waits in the output register while the next request is taken.
// Reset clears the card count and the output valid; the store is not cleared.
module ordered_unique_card_list #(
  parameter int DEPTH = ouc_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ouc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ouc_pkg::out_item_t  out_data
);
  import ouc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic              seq_idle;
  logic              res_valid;
  out_item_t         res_data;
  logic              out_free;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [CARD_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [CARD_W-1:0] mem_rd_data;
  logic              out_valid_r;
  out_item_t         out_data_r;

  assign in_stall = !seq_idle;
  assign out_free = !out_valid_r || !out_stall;

  ouc_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_data    (in_data),
    .idle        (seq_idle),
    .res_valid   (res_valid),
    .res_data    (res_data),
    .res_ack     (out_free),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ouc_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register: loads when the slot is free or its transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/ouc_checker.sv]
// Port-level checker for the ordered card list, bound to the top level
`include "ordered_unique_card_list_assert.svh"

module ouc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input ouc_pkg::out_item_t out_data
);
  import ouc_pkg::*;

  logic out_wait;
  logic out_dup;
  logic out_empty;

  // result held back by the receiver, and results by status
  assign out_wait  = out_valid && out_stall;
  assign out_dup   = out_valid && (out_data.status == ST_DUP);
  assign out_empty = out_valid && (out_data.status == ST_EMPTY);

  // result channel quiet straight after reset
  `OUC_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result stays put
  `OUC_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_data), "stalled result changed")

  // cards are distinct, so a match count never exceeds one
  `OUC_ASSERT(a_match_max, out_valid |-> out_data.match_count <= 7'd1, "match count above one")

  // a rejected duplicate is still held
  `OUC_ASSERT(a_dup_held, out_dup |-> out_data.match_count == 7'd1, "duplicate without match")

  // an empty report leaves nothing held
  `OUC_ASSERT(a_empty_occ, out_empty |-> out_data.occupancy == 7'd0, "empty with cards held")

endmodule

bind ordered_unique_card_list ouc_checker u_ouc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
